/* src/cursor_array_list_engine_assert.svh */
// Assertion macros for the cursor array list engine.
// Included by the top level; no other dependencies.
`ifndef CURSOR_ARRAY_LIST_ENGINE_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define CALE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define CALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CALE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/cale_pkg.sv */
// Shared constants and code types for the cursor array list engine.
// No dependencies.
package cale_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths on the channels
    localparam int OP_W   = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 11;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 4'd0,
        OP_APPEND  = 4'd1,
        OP_REMOVE  = 4'd2,
        OP_START   = 4'd3,
        OP_END     = 4'd4,
        OP_PREV    = 4'd5,
        OP_NEXT    = 4'd6,
        OP_MOVE_TO = 4'd7,
        OP_READ    = 4'd8,
        OP_COUNT   = 4'd9,
        OP_CLEAR   = 4'd10
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_ELEM = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

endpackage

/* src/cale_if.sv */
// Request and response channel interfaces of the cursor array list engine.
// Depends on cale_pkg for the field widths.
interface cale_req_if import cale_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;

    modport source (output valid, output opcode, output value, output position,
                    input ready);
    modport sink   (input valid, input opcode, input value, input position,
                    output ready);
endinterface

interface cale_rsp_if import cale_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  data;
    logic [POS_W-1:0]  match_count;
    logic [POS_W-1:0]  length;
    logic [POS_W-1:0]  cursor;
    logic [STAT_W-1:0] status;

    modport source (output valid, output data, output match_count, output length,
                    output cursor, output status, input ready);
    modport sink   (input valid, input data, input match_count, input length,
                    input cursor, input status, output ready);
endinterface

/* src/cale_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cursor_array_list_engine.sv */
// Cursor array list engine: top level with the sequencer over the entry store.
// Depends on cale_pkg, cale_if.sv, cale_ram and the assertion macro header.
//
//  channel  dir  handshake       payload
//  i_req    in   valid / ready   opcode, value, position
//  o_rsp    out  valid / ready   data, match_count, length, cursor, status
//
// One request at a time. Insert shifts the entries from the cursor up one slot
// (S_SHIFT_UP), or none at the end of the list, then writes the value (S_PUT);
// remove shifts them down (S_SHIFT_DN); count walks a nonempty list (S_COUNT);
// read goes via S_READ; the rest, and any flagged one, go to S_FIN. The walks
// move one entry per cycle through the single read and write ports of the store.
// Reset clears length, cursor and the handshake state; the store is not cleared.
// A response waiting on o_rsp does not block accepting the next request; a
// finished request holds in its final state until the output register frees.
`include "cursor_array_list_engine_assert.svh"

module cursor_array_list_engine import cale_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cale_req_if.sink  i_req,
    cale_rsp_if.source o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [DATA_WIDTH-1:0] DMIN = DATA_WIDTH'(64'd1 << (DATA_WIDTH - 1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_READ,
        S_COUNT,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_cursor;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_left;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_first;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_match;
    logic [DATA_WIDTH-1:0] r_res_data;
    t_status               r_res_status;

    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_data;
    logic [POS_W-1:0]      r_out_match;
    logic [POS_W-1:0]      r_out_len;
    logic [POS_W-1:0]      r_out_cur;
    logic [STAT_W-1:0]     r_out_status;

    logic                  accept;
    t_op                   op;
    logic [DATA_WIDTH-1:0] v_in;
    logic [CW-1:0]         ins_cur;
    logic                  full;
    logic                  has_elem;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // request decode
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign op          = t_op'(i_req.opcode);
    assign v_in        = DATA_WIDTH'(64'(signed'(i_req.value)));
    assign ins_cur     = (r_cursor > r_count) ? r_count : r_cursor;
    assign full        = (r_count == CW'(CAPACITY));
    assign has_elem    = (r_cursor < r_count);

    // store port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_addr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept && op == OP_APPEND && !full) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_count);
                    ram_wdata = v_in;
                end
                if (accept && op == OP_READ && has_elem) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_cursor);
                end
            end
            S_SHIFT_UP: begin
                ram_we    = r_rd_vld;
                ram_waddr = r_rd_addr + AW'(1);
                ram_re    = (r_left != '0);
            end
            S_SHIFT_DN: begin
                ram_we    = r_rd_vld && !r_first;
                ram_waddr = r_rd_addr - AW'(1);
                ram_re    = (r_left != '0);
            end
            S_COUNT: begin
                ram_re = (r_left != '0);
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cursor);
                ram_wdata = r_val;
            end
            default: begin
            end
        endcase
    end

    cale_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, list state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drained response; in S_FIN the load below handles the register
            if (r_out_valid && o_rsp.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_data   <= '0;
                        r_res_status <= ST_OK;
                        r_match      <= '0;
                        r_rd_vld     <= 1'b0;
                        r_first      <= 1'b1;
                        r_val        <= v_in;
                        r_state      <= S_FIN;
                        unique case (op)
                            OP_INSERT: begin
                                if (full) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_cursor <= ins_cur;
                                    r_idx    <= AW'(r_count - CW'(1));
                                    r_left   <= r_count - ins_cur;
                                    r_state  <= (ins_cur == r_count) ? S_PUT : S_SHIFT_UP;
                                end
                            end
                            OP_APPEND: begin
                                if (full) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            OP_REMOVE: begin
                                if (has_elem) begin
                                    r_idx   <= AW'(r_cursor);
                                    r_left  <= r_count - r_cursor;
                                    r_state <= S_SHIFT_DN;
                                end else begin
                                    r_res_data   <= DMIN;
                                    r_res_status <= ST_NO_ELEM;
                                end
                            end
                            OP_START: r_cursor <= '0;
                            OP_END: begin
                                r_cursor <= (r_count != '0) ? r_count - CW'(1) : '0;
                            end
                            OP_PREV: begin
                                if (r_cursor != '0) begin
                                    r_cursor <= r_cursor - CW'(1);
                                end
                            end
                            OP_NEXT: begin
                                if (has_elem) begin
                                    r_cursor <= r_cursor + CW'(1);
                                end
                            end
                            OP_MOVE_TO: begin
                                if (32'(i_req.position) <= 32'(r_count)) begin
                                    r_cursor <= CW'(i_req.position);
                                end else begin
                                    r_res_status <= ST_RANGE;
                                end
                            end
                            OP_READ: begin
                                if (has_elem) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_res_data   <= DMIN;
                                    r_res_status <= ST_NO_ELEM;
                                end
                            end
                            OP_COUNT: begin
                                if (r_count != '0) begin
                                    r_idx   <= '0;
                                    r_left  <= r_count;
                                    r_state <= S_COUNT;
                                end
                            end
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_cursor <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // walk down from the tail, each entry moves up one slot
                S_SHIFT_UP: begin
                    r_rd_vld  <= ram_re;
                    r_rd_addr <= r_idx;
                    if (ram_re) begin
                        r_idx  <= r_idx - AW'(1);
                        r_left <= r_left - CW'(1);
                    end
                    if (r_left == '0) begin
                        r_state <= S_PUT;
                    end
                end
                // drop the new value into the gap at the cursor
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_FIN;
                end
                // walk up from the cursor, first read is the removed entry
                S_SHIFT_DN: begin
                    r_rd_vld  <= ram_re;
                    r_rd_addr <= r_idx;
                    if (ram_re) begin
                        r_idx  <= r_idx + AW'(1);
                        r_left <= r_left - CW'(1);
                    end
                    if (r_rd_vld && r_first) begin
                        r_res_data <= ram_rdata;
                        r_first    <= 1'b0;
                    end
                    if (r_left == '0) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FIN;
                    end
                end
                S_READ: begin
                    r_res_data <= ram_rdata;
                    r_state    <= S_FIN;
                end
                // one compare per cycle against the search value
                S_COUNT: begin
                    r_rd_vld <= ram_re;
                    if (ram_re) begin
                        r_idx  <= r_idx + AW'(1);
                        r_left <= r_left - CW'(1);
                    end
                    if (r_rd_vld && ram_rdata == r_val) begin
                        r_match <= r_match + CW'(1);
                    end
                    if (r_left == '0) begin
                        r_state <= S_FIN;
                    end
                end
                // hand the response over once the output register is free
                S_FIN: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= VAL_W'(64'(signed'(r_res_data)));
                        r_out_match  <= POS_W'(r_match);
                        r_out_len    <= POS_W'(r_count);
                        r_out_cur    <= POS_W'(r_cursor);
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.data        = r_out_data;
    assign o_rsp.match_count = r_out_match;
    assign o_rsp.length      = r_out_len;
    assign o_rsp.cursor      = r_out_cur;
    assign o_rsp.status      = r_out_status;

    // checks
    `CALE_ASSERT_NOW(a_cursor_in_list, i_clk, i_rst_n, 1'b1,
                     r_cursor <= r_count, "cursor past end of list")
    `CALE_ASSERT_NOW(a_len_in_cap, i_clk, i_rst_n, 1'b1,
                     32'(r_count) <= CAPACITY, "length above capacity")
    `CALE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept,
                      r_state != S_IDLE, "sequencer idle after accept")
    `CALE_ASSERT_NOW(a_put_not_full, i_clk, i_rst_n, r_state == S_PUT,
                     !full, "insert into full list")

endmodule

/* tb/sv/tb_cursor_array_list_engine.sv */
// Self-checking testbench for the cursor array list engine: directed table, then random requests.
// Depends on cale_pkg, the cale_req_if / cale_rsp_if interfaces and the engine top level.
`timescale 1ns / 1ps

module tb_cursor_array_list_engine;
    import cale_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 10;
    localparam int IDLE_PCT         = 28;
    localparam int RANDOM_REQUESTS  = 580;
    localparam int SINK_HOLD_CYCLES = 300;
    // long enough for the longest walk, over a full list, plus its overhead
    localparam int DRAIN_CYCLES     = CAPACITY_DEF + 16;
    localparam int QUIET_LIMIT      = 16 * CAPACITY_DEF;
    localparam int DIR_ROWS         = 38;

    localparam logic [VAL_W-1:0] NO_ELEM_DATA = 32'h8000_0000;
    // opcodes the engine treats as no-ops
    localparam logic [OP_W-1:0]  OP_UNUSED_LO = 4'hB;
    localparam logic [OP_W-1:0]  OP_UNUSED_HI = 4'hF;

    typedef struct packed {
        logic [VAL_W-1:0] data;
        logic [POS_W-1:0] match_count;
        logic [POS_W-1:0] length;
        logic [POS_W-1:0] cursor;
        t_status          status;
    } t_list_result;

    // one line of the directed table; expected fields used only when typed is set
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] reps;
        logic             typed;
        logic [VAL_W-1:0] e_data;
        logic [POS_W-1:0] e_count;
        logic [POS_W-1:0] e_len;
        logic [POS_W-1:0] e_cur;
        t_status          e_status;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cale_req_if req_if ();
    cale_rsp_if rsp_if ();

    cursor_array_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // shadow copy of the list
    logic [VAL_W-1:0] shadow_entries [CAPACITY_DEF];
    int               shadow_len;
    int               shadow_cur;

    t_list_result pending_results [$];
    t_dir_row     directed_rows [DIR_ROWS];

    int  fail_count;
    int  accepted_requests;
    int  checked_results;
    int  status_seen [4];
    int  quiet_cycles;
    int  src_idle_pct;
    int  sink_idle_pct;
    bit  rsp_hold_req;

    // apply one request to the shadow list and return the response it should produce
    function automatic t_list_result apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [VAL_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        t_list_result res;
        res = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_len >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = shadow_len; i > shadow_cur; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[shadow_cur] = val;
                    shadow_len++;
                end
            end
            OP_APPEND: begin
                if (shadow_len >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                end
            end
            OP_REMOVE: begin
                if (shadow_cur < shadow_len) begin
                    res.data = shadow_entries[shadow_cur];
                    for (int i = shadow_cur; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                end else begin
                    res.data   = NO_ELEM_DATA;
                    res.status = ST_NO_ELEM;
                end
            end
            OP_START: shadow_cur = 0;
            OP_END:   shadow_cur = (shadow_len > 0) ? shadow_len - 1 : 0;
            OP_PREV:  if (shadow_cur > 0) shadow_cur--;
            OP_NEXT:  if (shadow_cur < shadow_len) shadow_cur++;
            OP_MOVE_TO: begin
                if (int'(pos) <= shadow_len) shadow_cur = int'(pos);
                else res.status = ST_RANGE;
            end
            OP_READ: begin
                if (shadow_cur < shadow_len) begin
                    res.data = shadow_entries[shadow_cur];
                end else begin
                    res.data   = NO_ELEM_DATA;
                    res.status = ST_NO_ELEM;
                end
            end
            OP_COUNT: begin
                for (int i = 0; i < shadow_len; i++)
                    if (shadow_entries[i] == val) res.match_count++;
            end
            OP_CLEAR: begin
                shadow_len = 0;
                shadow_cur = 0;
            end
            default: ;
        endcase
        res.length = POS_W'(shadow_len);
        res.cursor = POS_W'(shadow_cur);
        return res;
    endfunction

    // values biased toward extremes and a small set that makes count hits likely
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return NO_ELEM_DATA;
            1:       return 32'h7FFF_FFFF;
            2:       return {VAL_W{1'b1}};
            3, 4, 5: return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    // draw a request from the current shadow state; len_cap keeps walks short
    task automatic make_random_request(input int len_cap,
                                       output logic [OP_W-1:0] op,
                                       output logic [VAL_W-1:0] val,
                                       output logic [POS_W-1:0] pos);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 16)      op = OP_INSERT;
        else if (roll < 30) op = OP_APPEND;
        else if (roll < 44) op = OP_REMOVE;
        else if (roll < 48) op = OP_START;
        else if (roll < 53) op = OP_END;
        else if (roll < 60) op = OP_PREV;
        else if (roll < 68) op = OP_NEXT;
        else if (roll < 78) op = OP_MOVE_TO;
        else if (roll < 88) op = OP_READ;
        else if (roll < 95) op = OP_COUNT;
        else if (roll < 96) op = OP_CLEAR;
        else                op = OP_UNUSED_LO + 4'($urandom_range(0, 4));
        if ((op == OP_INSERT || op == OP_APPEND) && shadow_len >= len_cap &&
            $urandom_range(0, 9) < 8)
            op = OP_REMOVE;
        val = pick_value();
        if (op == OP_COUNT && shadow_len > 0 && $urandom_range(0, 1))
            val = shadow_entries[$urandom_range(0, shadow_len - 1)];
        case ($urandom_range(0, 9))
            0, 1:    pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            2:       pos = POS_W'(shadow_len + 1 + int'($urandom_range(0, 3)));
            default: pos = POS_W'($urandom_range(0, shadow_len));
        endcase
    endtask

    // drive one request, wait for the accept, then queue its expected response
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos, input logic use_typed,
                                input t_list_result typed_res);
        t_list_result predicted;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.value    <= val;
        req_if.position <= pos;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        predicted = apply_list_op(op, val, pos);
        pending_results.push_back(use_typed ? typed_res : predicted);
        accepted_requests++;
    endtask

    // response receiver: random back-pressure plus one long hold-off
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= i_rst_n && ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin : check_responses
        t_list_result got;
        t_list_result want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = '{rsp_if.data, rsp_if.match_count, rsp_if.length, rsp_if.cursor,
                    t_status'(rsp_if.status)};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected response: data %h length %0d cursor %0d status %0d",
                             got.data, got.length, got.cursor, got.status);
            end else begin
                want = pending_results.pop_front();
                checked_results++;
                status_seen[got.status]++;
                if (got.data !== want.data || got.match_count !== want.match_count ||
                    got.length !== want.length || got.cursor !== want.cursor ||
                    got.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch on response %0d: data %h/%h count %0d/%0d ",
                                  "length %0d/%0d cursor %0d/%0d status %0d/%0d (exp/got)"},
                                 checked_results, want.data, got.data, want.match_count,
                                 got.match_count, want.length, got.length, want.cursor,
                                 got.cursor, want.status, got.status);
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no request or response moved for %0d cycles", quiet_cycles);
            $display("tb_cursor_array_list_engine NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_dir_row         row;
        t_list_result     typed_res;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        int               len_cap;

        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.opcode   <= '0;
        req_if.value    <= '0;
        req_if.position <= '0;
        accepted_requests = 0;
        src_idle_pct    = IDLE_PCT;
        sink_idle_pct   = IDLE_PCT;
        rsp_hold_req    = 1'b0;
        shadow_len      = 0;
        shadow_cur      = 0;
        len_cap         = 4;

        //  op            value         pos  reps typ data          cnt  len   cur   status
        directed_rows = '{
            '{OP_READ,     32'h0,        0,    1, 1, NO_ELEM_DATA, 0,   0,    0,    ST_NO_ELEM},
            '{OP_REMOVE,   32'h0,        0,    1, 1, NO_ELEM_DATA, 0,   0,    0,    ST_NO_ELEM},
            '{OP_END,      32'h0,        0,    1, 1, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_PREV,     32'h0,        0,    1, 1, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_NEXT,     32'h0,        0,    1, 1, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_MOVE_TO,  32'h0,        1,    1, 1, 32'h0,        0,   0,    0,    ST_RANGE},
            '{OP_COUNT,    32'h0,        0,    1, 1, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_APPEND,   32'h7FFF_FFFF, 0,   1, 1, 32'h0,        0,   1,    0,    ST_OK},
            '{OP_APPEND,   32'h8000_0000, 2047, 1, 1, 32'h0,       0,   2,    0,    ST_OK},
            '{OP_INSERT,   32'h0,        0,    1, 1, 32'h0,        0,   3,    0,    ST_OK},
            '{OP_READ,     32'h0,        0,    1, 1, 32'h0,        0,   3,    0,    ST_OK},
            '{OP_NEXT,     32'h0,        0,    1, 1, 32'h0,        0,   3,    1,    ST_OK},
            '{OP_READ,     32'h0,        0,    1, 1, 32'h7FFF_FFFF, 0,  3,    1,    ST_OK},
            '{OP_COUNT,    32'h8000_0000, 0,   1, 1, 32'h0,        1,   3,    1,    ST_OK},
            '{OP_MOVE_TO,  32'h0,        3,    1, 1, 32'h0,        0,   3,    3,    ST_OK},
            '{OP_READ,     32'h0,        0,    1, 1, NO_ELEM_DATA, 0,   3,    3,    ST_NO_ELEM},
            '{OP_NEXT,     32'h0,        0,    1, 1, 32'h0,        0,   3,    3,    ST_OK},
            '{OP_INSERT,   32'hFFFF_FFFF, 0,   1, 0, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_REMOVE,   32'h0,        0,    1, 1, 32'hFFFF_FFFF, 0,  3,    3,    ST_OK},
            '{OP_END,      32'h0,        0,    1, 1, 32'h0,        0,   3,    2,    ST_OK},
            '{OP_PREV,     32'h0,        0,    1, 0, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_INSERT,   32'h1234_5678, 0,   1, 0, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_MOVE_TO,  32'h0,        2047, 1, 1, 32'h0,        0,   4,    1,    ST_RANGE},
            '{OP_UNUSED_LO, 32'h0,       0,    1, 1, 32'h0,        0,   4,    1,    ST_OK},
            '{OP_UNUSED_HI, 32'hFFFF_FFFF, 2047, 1, 1, 32'h0,      0,   4,    1,    ST_OK},
            '{OP_START,    32'h0,        0,    1, 1, 32'h0,        0,   4,    0,    ST_OK},
            '{OP_CLEAR,    32'h0,        0,    1, 1, 32'h0,        0,   0,    0,    ST_OK},
            // fill to capacity with distinct values
            '{OP_APPEND,   32'h0000_1000, 0, 1024, 0, 32'h0,       0,   0,    0,    ST_OK},
            '{OP_APPEND,   32'h5555_5555, 0,   1, 1, 32'h0,        0,   1024, 0,    ST_FULL},
            '{OP_INSERT,   32'hAAAA_AAAA, 0,   1, 1, 32'h0,        0,   1024, 0,    ST_FULL},
            '{OP_COUNT,    32'h0000_1005, 0,   1, 0, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_END,      32'h0,        0,    1, 1, 32'h0,        0,   1024, 1023, ST_OK},
            '{OP_NEXT,     32'h0,        0,    1, 1, 32'h0,        0,   1024, 1024, ST_OK},
            '{OP_REMOVE,   32'h0,        0,    1, 1, NO_ELEM_DATA, 0,   1024, 1024, ST_NO_ELEM},
            '{OP_START,    32'h0,        0,    1, 0, 32'h0,        0,   0,    0,    ST_OK},
            // longest shift in each direction
            '{OP_REMOVE,   32'h0,        0,    1, 0, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_INSERT,   32'h8000_0000, 0,   1, 0, 32'h0,        0,   0,    0,    ST_OK},
            '{OP_CLEAR,    32'h0,        0,    1, 1, 32'h0,        0,   0,    0,    ST_OK}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            typed_res = '{row.e_data, row.e_count, row.e_len, row.e_cur, row.e_status};
            for (int k = 0; k < row.reps; k++)
                send_request(row.op, row.value + k, row.position, row.typed, typed_res);
        end

        // random requests, list length kept under a cap that changes every hundred
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       len_cap = 4;
                    1:       len_cap = 24;
                    default: len_cap = 96;
                endcase
            end
            if (n == 150) rsp_hold_req = 1'b1;
            if (n == 250) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (n == 350) begin
                src_idle_pct  = IDLE_PCT;
                sink_idle_pct = IDLE_PCT;
            end
            make_random_request(len_cap, op, val, pos);
            send_request(op, val, pos, 1'b0, '0);
        end
        req_if.valid <= 1'b0;

        // drain, then make sure nothing extra shows up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed rows incl. a full-list fill), %0d checked",
                 accepted_requests, DIR_ROWS, checked_results);
        $display("response status mix: ok %0d, full %0d, no element %0d, out of range %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NO_ELEM],
                 status_seen[ST_RANGE]);
        if (fail_count == 0)
            $display("tb_cursor_array_list_engine OK");
        else
            $display("tb_cursor_array_list_engine NOT OK");
        $finish;
    end

endmodule
